// File: hw/rtl/page_pool_replacement_assert.svh
// Assertion macros for the page pool replacement block.
// Expects clk and rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef PAGE_POOL_REPLACEMENT_ASSERT_SVH
`define PAGE_POOL_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
`define PPR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PPR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PPR_ASSERT_ALWAYS(lbl, expr, msg)
`define PPR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hw/rtl/ppr_pkg.sv
// Shared types and constants of the page pool replacement block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppr_pkg;
  localparam int ACTION_W   = 2;
  localparam int CAP_W      = 7;
  localparam int FILE_W     = 25;
  localparam int CFG_DATA_W = 25;

  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  localparam logic CFG_POOL_CAPACITY      = 1'b0;
  localparam logic CFG_INITIAL_FILE_PAGES = 1'b1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd32;
  localparam logic [CAP_W-1:0]  CAP_MAX    = 7'd127;
  localparam logic [FILE_W-1:0] FILE_RESET = 25'd1;
  localparam logic [FILE_W-1:0] FILE_MAX   = 25'h1FFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_RD,
    ST_L_CMP,
    ST_MISS,
    ST_Q_CHK,
    ST_Q_NXT,
    ST_V_DAT,
    ST_INSERT,
    ST_EMIT,
    ST_F_CHK,
    ST_F_DAT,
    ST_F_END
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/ppr_in_if.sv
// Request channel of the page pool replacement block.
// Depends on ppr_pkg for the action width.
`timescale 1ns / 1ps
`default_nettype none
interface ppr_in_if #(parameter int PAGE_BITS = 24) ();
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::ACTION_W-1:0] action;
  logic [PAGE_BITS-1:0]        page_number;
  modport source (output valid, action, page_number, input ready);
  modport sink (input valid, action, page_number, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ppr_out_if.sv
// Result channel of the page pool replacement block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ppr_out_if #(parameter int PAGE_BITS = 24, parameter int SLOTS = 64) ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [$clog2(SLOTS)-1:0] slot;
  logic                     evicted_valid;
  logic [PAGE_BITS-1:0]     evicted_page;
  logic                     writeback_valid;
  logic [PAGE_BITS-1:0]     writeback_page;
  logic                     from_file;
  logic                     capacity_grown;
  logic                     full_error;
  logic                     last;
  modport source (output valid, hit, slot, evicted_valid, evicted_page, writeback_valid,
                  writeback_page, from_file, capacity_grown, full_error, last,
                  input ready);
  modport sink (input valid, hit, slot, evicted_valid, evicted_page, writeback_valid,
                writeback_page, from_file, capacity_grown, full_error, last,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ppr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/page_pool_replacement.sv
// Page pool with FIFO replacement, pinning and flush of dirty pages.
// A read or write scans the tags slot by slot up to a hit. A miss under capacity takes a free
// slot; at capacity it evicts the oldest unpinned page, walking past pinned ones, or grows the
// capacity when all listed pages are pinned. A flush walks every slot and emits a writeback
// per dirty page, marking the final result last. One request at a time.
// Synchronous active-low reset clears valid, pinned and dirty bits, list length and used count.
`timescale 1ns / 1ps
`default_nettype none
`include "page_pool_replacement_assert.svh"
module page_pool_replacement #(
  parameter int SLOTS     = 64,
  parameter int PAGE_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ppr_in_if.sink                              in_chan,
  ppr_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [ppr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int SW = $clog2(SLOTS);
  localparam int QW = $clog2(SLOTS + 1);
  localparam int CW = (QW > ppr_pkg::CAP_W) ? QW : ppr_pkg::CAP_W;
  localparam int FW = (PAGE_BITS + 1 > ppr_pkg::FILE_W) ? PAGE_BITS + 1 : ppr_pkg::FILE_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  ppr_pkg::state_t state_r, state_nxt;
  logic [ppr_pkg::ACTION_W-1:0] act_r, act_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [SW-1:0] idx_r, idx_nxt, free_idx_r, free_idx_nxt;
  logic free_found_r, free_found_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt, pinned_r, pinned_nxt, dirty_r, dirty_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [QW-1:0] qlen_r, qlen_nxt, qcnt_r, qcnt_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [ppr_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [ppr_pkg::FILE_W-1:0] fpc_r, fpc_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic r_hit_r, r_hit_nxt, r_ev_r, r_ev_nxt, r_wb_r, r_wb_nxt, r_ff_r, r_ff_nxt;
  logic r_grown_r, r_grown_nxt, r_full_r, r_full_nxt, r_last_r, r_last_nxt;
  logic [PAGE_BITS-1:0] r_evp_r, r_evp_nxt, r_wbp_r, r_wbp_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_slot_r, pend_slot_nxt;
  logic [PAGE_BITS-1:0] pend_tag_r, pend_tag_nxt;

  logic ov_r, ov_nxt;
  logic o_hit_r, o_hit_nxt, o_ev_r, o_ev_nxt, o_wb_r, o_wb_nxt, o_ff_r, o_ff_nxt;
  logic o_grown_r, o_grown_nxt, o_full_r, o_full_nxt, o_last_r, o_last_nxt;
  logic [SW-1:0] o_slot_r, o_slot_nxt;
  logic [PAGE_BITS-1:0] o_evp_r, o_evp_nxt, o_wbp_r, o_wbp_nxt;

  logic ld;
  logic ld_hit, ld_ev, ld_wb, ld_ff, ld_grown, ld_full, ld_last;
  logic [SW-1:0] ld_slot;
  logic [PAGE_BITS-1:0] ld_evp, ld_wbp;

  logic out_free;
  logic [SW-1:0] tag_raddr;
  logic [PAGE_BITS-1:0] tag_rdata;
  logic tag_we;
  logic [SW-1:0] next_rdata, next_waddr, next_wdata;
  logic next_we;

  assign out_free  = !ov_r || out_chan.ready;
  assign tag_raddr = (state_r == ppr_pkg::ST_Q_CHK) ? cur_r : idx_r;
  assign tag_we    = (state_r == ppr_pkg::ST_INSERT);

  always_comb begin
    next_we    = 1'b0;
    next_waddr = tail_r;
    next_wdata = slot_r;
    if (state_r == ppr_pkg::ST_V_DAT && cur_r != head_r) begin
      next_we    = 1'b1;
      next_waddr = prev_r;
      next_wdata = next_rdata;
    end else if (state_r == ppr_pkg::ST_INSERT && qlen_r != '0) begin
      next_we = 1'b1;
    end
  end

  ppr_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot_r),
    .wdata (page_r),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  ppr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cur_r),
    .rdata (next_rdata)
  );

  always_comb begin
    state_nxt = state_r;   act_nxt = act_r;     page_nxt = page_r;
    idx_nxt = idx_r;       free_idx_nxt = free_idx_r; free_found_nxt = free_found_r;
    valid_nxt = valid_r;   pinned_nxt = pinned_r; dirty_nxt = dirty_r;
    head_nxt = head_r;     tail_nxt = tail_r;   cur_nxt = cur_r;   prev_nxt = prev_r;
    qlen_nxt = qlen_r;     qcnt_nxt = qcnt_r;   used_nxt = used_r;
    cap_nxt = cap_r;       fpc_nxt = fpc_r;     slot_nxt = slot_r;
    r_hit_nxt = r_hit_r;   r_ev_nxt = r_ev_r;   r_wb_nxt = r_wb_r;  r_ff_nxt = r_ff_r;
    r_grown_nxt = r_grown_r; r_full_nxt = r_full_r; r_last_nxt = r_last_r;
    r_evp_nxt = r_evp_r;   r_wbp_nxt = r_wbp_r;
    pend_v_nxt = pend_v_r; pend_slot_nxt = pend_slot_r; pend_tag_nxt = pend_tag_r;
    ld = 1'b0;
    ld_hit = r_hit_r; ld_ev = r_ev_r; ld_wb = r_wb_r; ld_ff = r_ff_r;
    ld_grown = r_grown_r; ld_full = r_full_r; ld_last = r_last_r;
    ld_slot = slot_r; ld_evp = r_evp_r; ld_wbp = r_wbp_r;
    in_chan.ready = 1'b0;

    if (cfg_we) begin
      if (cfg_index == ppr_pkg::CFG_POOL_CAPACITY) begin
        cap_nxt = cfg_wdata[ppr_pkg::CAP_W-1:0];
      end else begin
        fpc_nxt = cfg_wdata[ppr_pkg::FILE_W-1:0];
      end
    end

    case (state_r)
      ppr_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          act_nxt = in_chan.action;
          page_nxt = in_chan.page_number;
          idx_nxt = '0;
          free_found_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          slot_nxt = '0;
          r_hit_nxt = 1'b0; r_ev_nxt = 1'b0; r_wb_nxt = 1'b0; r_ff_nxt = 1'b0;
          r_grown_nxt = 1'b0; r_full_nxt = 1'b0; r_last_nxt = 1'b1;
          r_evp_nxt = '0; r_wbp_nxt = '0;
          if (in_chan.action inside {ppr_pkg::ACT_READ, ppr_pkg::ACT_WRITE}) begin
            state_nxt = ppr_pkg::ST_L_RD;
          end else if (in_chan.action == ppr_pkg::ACT_FLUSH) begin
            state_nxt = ppr_pkg::ST_F_CHK;
          end else begin
            state_nxt = ppr_pkg::ST_EMIT;
          end
        end
      end
      ppr_pkg::ST_L_RD: begin
        state_nxt = ppr_pkg::ST_L_CMP;
      end
      ppr_pkg::ST_L_CMP: begin
        if (valid_r[idx_r] && tag_rdata == page_r) begin
          r_hit_nxt = 1'b1;
          slot_nxt = idx_r;
          if (act_r == ppr_pkg::ACT_WRITE) begin
            pinned_nxt[idx_r] = 1'b1;
            dirty_nxt[idx_r] = 1'b1;
          end
          state_nxt = ppr_pkg::ST_EMIT;
        end else begin
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ppr_pkg::ST_MISS;
          end else begin
            idx_nxt = idx_r + SW'(1);
            state_nxt = ppr_pkg::ST_L_RD;
          end
        end
      end
      ppr_pkg::ST_MISS: begin
        if (used_r < CW'(cap_r)) begin
          if (free_found_r) begin
            slot_nxt = free_idx_r;
            used_nxt = used_r + CW'(1);
            state_nxt = ppr_pkg::ST_INSERT;
          end else begin
            r_full_nxt = 1'b1;
            state_nxt = ppr_pkg::ST_EMIT;
          end
        end else begin
          cur_nxt = head_r;
          qcnt_nxt = qlen_r;
          state_nxt = ppr_pkg::ST_Q_CHK;
        end
      end
      ppr_pkg::ST_Q_CHK: begin
        if (qcnt_r == '0) begin
          if (free_found_r) begin
            slot_nxt = free_idx_r;
            used_nxt = used_r + CW'(1);
            if (cap_r < ppr_pkg::CAP_MAX) begin
              cap_nxt = cap_r + ppr_pkg::CAP_W'(1);
            end
            r_grown_nxt = 1'b1;
            state_nxt = ppr_pkg::ST_INSERT;
          end else begin
            r_full_nxt = 1'b1;
            state_nxt = ppr_pkg::ST_EMIT;
          end
        end else if (!pinned_r[cur_r]) begin
          state_nxt = ppr_pkg::ST_V_DAT;
        end else begin
          state_nxt = ppr_pkg::ST_Q_NXT;
        end
      end
      ppr_pkg::ST_Q_NXT: begin
        prev_nxt = cur_r;
        cur_nxt = next_rdata;
        qcnt_nxt = qcnt_r - QW'(1);
        state_nxt = ppr_pkg::ST_Q_CHK;
      end
      ppr_pkg::ST_V_DAT: begin
        r_ev_nxt = 1'b1;
        r_evp_nxt = tag_rdata;
        if (dirty_r[cur_r]) begin
          r_wb_nxt = 1'b1;
          r_wbp_nxt = tag_rdata;
        end
        if (cur_r == head_r) begin
          head_nxt = next_rdata;
        end
        if (cur_r == tail_r) begin
          tail_nxt = prev_r;
        end
        qlen_nxt = qlen_r - QW'(1);
        valid_nxt[cur_r] = 1'b0;
        pinned_nxt[cur_r] = 1'b0;
        dirty_nxt[cur_r] = 1'b0;
        slot_nxt = cur_r;
        state_nxt = ppr_pkg::ST_INSERT;
      end
      ppr_pkg::ST_INSERT: begin
        if (FW'(page_r) < FW'(fpc_r)) begin
          r_ff_nxt = 1'b1;
        end else if (fpc_r < ppr_pkg::FILE_MAX) begin
          fpc_nxt = fpc_r + ppr_pkg::FILE_W'(1);
        end
        valid_nxt[slot_r] = 1'b1;
        pinned_nxt[slot_r] = (act_r == ppr_pkg::ACT_WRITE);
        dirty_nxt[slot_r] = (act_r == ppr_pkg::ACT_WRITE);
        if (qlen_r == '0) begin
          head_nxt = slot_r;
        end
        tail_nxt = slot_r;
        qlen_nxt = qlen_r + QW'(1);
        state_nxt = ppr_pkg::ST_EMIT;
      end
      ppr_pkg::ST_EMIT: begin
        if (out_free) begin
          ld = 1'b1;
          state_nxt = ppr_pkg::ST_IDLE;
        end
      end
      ppr_pkg::ST_F_CHK: begin
        if (valid_r[idx_r] && dirty_r[idx_r]) begin
          state_nxt = ppr_pkg::ST_F_DAT;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ppr_pkg::ST_F_END;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      ppr_pkg::ST_F_DAT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            ld = 1'b1;
            ld_slot = pend_slot_r; ld_wb = 1'b1; ld_wbp = pend_tag_r; ld_last = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_slot_nxt = idx_r;
          pend_tag_nxt = tag_rdata;
          dirty_nxt[idx_r] = 1'b0;
          if (idx_r == LAST_IDX) begin
            state_nxt = ppr_pkg::ST_F_END;
          end else begin
            idx_nxt = idx_r + SW'(1);
            state_nxt = ppr_pkg::ST_F_CHK;
          end
        end
      end
      ppr_pkg::ST_F_END: begin
        if (out_free) begin
          ld = 1'b1;
          if (pend_v_r) begin
            ld_slot = pend_slot_r; ld_wb = 1'b1; ld_wbp = pend_tag_r;
          end
          state_nxt = ppr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppr_pkg::ST_IDLE;
      end
    endcase

    ov_nxt = ov_r && !out_chan.ready;
    o_hit_nxt = o_hit_r; o_ev_nxt = o_ev_r; o_wb_nxt = o_wb_r; o_ff_nxt = o_ff_r;
    o_grown_nxt = o_grown_r; o_full_nxt = o_full_r; o_last_nxt = o_last_r;
    o_slot_nxt = o_slot_r; o_evp_nxt = o_evp_r; o_wbp_nxt = o_wbp_r;
    if (ld) begin
      ov_nxt = 1'b1;
      o_hit_nxt = ld_hit; o_ev_nxt = ld_ev; o_wb_nxt = ld_wb; o_ff_nxt = ld_ff;
      o_grown_nxt = ld_grown; o_full_nxt = ld_full; o_last_nxt = ld_last;
      o_slot_nxt = ld_slot; o_evp_nxt = ld_evp; o_wbp_nxt = ld_wbp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppr_pkg::ST_IDLE;
      valid_r <= '0;
      pinned_r <= '0;
      dirty_r <= '0;
      qlen_r <= '0;
      used_r <= '0;
      cap_r <= ppr_pkg::CAP_RESET;
      fpc_r <= ppr_pkg::FILE_RESET;
      pend_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pinned_r <= pinned_nxt;
      dirty_r <= dirty_nxt;
      qlen_r <= qlen_nxt;
      used_r <= used_nxt;
      cap_r <= cap_nxt;
      fpc_r <= fpc_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;       page_r <= page_nxt;
    idx_r <= idx_nxt;       free_idx_r <= free_idx_nxt; free_found_r <= free_found_nxt;
    head_r <= head_nxt;     tail_r <= tail_nxt;  cur_r <= cur_nxt;  prev_r <= prev_nxt;
    qcnt_r <= qcnt_nxt;     slot_r <= slot_nxt;
    r_hit_r <= r_hit_nxt;   r_ev_r <= r_ev_nxt;  r_wb_r <= r_wb_nxt; r_ff_r <= r_ff_nxt;
    r_grown_r <= r_grown_nxt; r_full_r <= r_full_nxt; r_last_r <= r_last_nxt;
    r_evp_r <= r_evp_nxt;   r_wbp_r <= r_wbp_nxt;
    pend_slot_r <= pend_slot_nxt; pend_tag_r <= pend_tag_nxt;
    o_hit_r <= o_hit_nxt;   o_ev_r <= o_ev_nxt;  o_wb_r <= o_wb_nxt; o_ff_r <= o_ff_nxt;
    o_grown_r <= o_grown_nxt; o_full_r <= o_full_nxt; o_last_r <= o_last_nxt;
    o_slot_r <= o_slot_nxt; o_evp_r <= o_evp_nxt; o_wbp_r <= o_wbp_nxt;
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.hit             = o_hit_r;
  assign out_chan.slot            = o_slot_r;
  assign out_chan.evicted_valid   = o_ev_r;
  assign out_chan.evicted_page    = o_evp_r;
  assign out_chan.writeback_valid = o_wb_r;
  assign out_chan.writeback_page  = o_wbp_r;
  assign out_chan.from_file       = o_ff_r;
  assign out_chan.capacity_grown  = o_grown_r;
  assign out_chan.full_error      = o_full_r;
  assign out_chan.last            = o_last_r;

  `PPR_ASSERT_NEXT(a_accept_leaves_idle, in_chan.valid && in_chan.ready, state_r != ppr_pkg::ST_IDLE, "request accepted but sequencer stayed idle")
  `PPR_ASSERT_ALWAYS(a_list_len_matches, 32'(qlen_r) == 32'($countones(valid_r)), "insertion list length differs from resident slot count")
  `PPR_ASSERT_ALWAYS(a_used_bound, 32'(used_r) <= 32'(SLOTS), "used slot count beyond physical slots")
endmodule
`default_nettype wire
